@@ sv/c6502_pkg.sv @@
`timescale 1ns / 1ps
package c6502_pkg;

  typedef enum logic [3:0] {
    K_UNKNOWN, K_IMPLIED, K_MEM, K_JMPA, K_JMPI, K_JSR, K_RTS, K_RTI, K_BRK, K_PUSH, K_PULL
  } kind_t;

  typedef enum logic [2:0] {OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_ADC} oper_t;

  typedef enum logic [3:0] {
    AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY, AM_INDX, AM_INDY
  } mode_t;

  typedef struct packed {
    kind_t kind;
    oper_t oper;
    mode_t mode;
  } decoded_t;

  localparam logic [7:0] STATUS_RESET = 8'h24;
  localparam logic [7:0] SP_RESET     = 8'hFD;
  localparam logic [7:0] BRK_BITS     = 8'h30;
  localparam logic [7:0] STACK_PAGE   = 8'h01;
  localparam logic [15:0] IRQ_VECTOR  = 16'hFFFE;

  localparam logic [7:0] OPC_PHA = 8'h48;
  localparam logic [7:0] OPC_PLA = 8'h68;

  // Opcode decode into instruction class, operation and addressing mode.
  function automatic decoded_t decode(input logic [7:0] op);
    decoded_t d;
    d = '{kind: K_UNKNOWN, oper: OP_LDA, mode: AM_IMM};
    case (op)
      8'hA9: d = '{K_MEM, OP_LDA, AM_IMM};
      8'hA5: d = '{K_MEM, OP_LDA, AM_ZP};
      8'hB5: d = '{K_MEM, OP_LDA, AM_ZPX};
      8'hAD: d = '{K_MEM, OP_LDA, AM_ABS};
      8'hBD: d = '{K_MEM, OP_LDA, AM_ABSX};
      8'hB9: d = '{K_MEM, OP_LDA, AM_ABSY};
      8'hA1: d = '{K_MEM, OP_LDA, AM_INDX};
      8'hB1: d = '{K_MEM, OP_LDA, AM_INDY};
      8'hA2: d = '{K_MEM, OP_LDX, AM_IMM};
      8'hA6: d = '{K_MEM, OP_LDX, AM_ZP};
      8'hB6: d = '{K_MEM, OP_LDX, AM_ZPY};
      8'hAE: d = '{K_MEM, OP_LDX, AM_ABS};
      8'hBE: d = '{K_MEM, OP_LDX, AM_ABSY};
      8'hA0: d = '{K_MEM, OP_LDY, AM_IMM};
      8'hA4: d = '{K_MEM, OP_LDY, AM_ZP};
      8'hB4: d = '{K_MEM, OP_LDY, AM_ZPX};
      8'hAC: d = '{K_MEM, OP_LDY, AM_ABS};
      8'hBC: d = '{K_MEM, OP_LDY, AM_ABSX};
      8'h85: d = '{K_MEM, OP_STA, AM_ZP};
      8'h95: d = '{K_MEM, OP_STA, AM_ZPX};
      8'h8D: d = '{K_MEM, OP_STA, AM_ABS};
      8'h9D: d = '{K_MEM, OP_STA, AM_ABSX};
      8'h99: d = '{K_MEM, OP_STA, AM_ABSY};
      8'h81: d = '{K_MEM, OP_STA, AM_INDX};
      8'h91: d = '{K_MEM, OP_STA, AM_INDY};
      8'h69: d = '{K_MEM, OP_ADC, AM_IMM};
      8'h65: d = '{K_MEM, OP_ADC, AM_ZP};
      8'h75: d = '{K_MEM, OP_ADC, AM_ZPX};
      8'h6D: d = '{K_MEM, OP_ADC, AM_ABS};
      8'h7D: d = '{K_MEM, OP_ADC, AM_ABSX};
      8'h79: d = '{K_MEM, OP_ADC, AM_ABSY};
      8'h61: d = '{K_MEM, OP_ADC, AM_INDX};
      8'h71: d = '{K_MEM, OP_ADC, AM_INDY};
      8'hAA, 8'hA8, 8'h8A, 8'h98, 8'hBA, 8'h9A, 8'hE8, 8'hC8, 8'hCA, 8'h88,
      8'h18, 8'h38, 8'hD8, 8'h58, 8'h78, 8'hEA: d.kind = K_IMPLIED;
      8'h4C: d.kind = K_JMPA;
      8'h6C: d.kind = K_JMPI;
      8'h20: d.kind = K_JSR;
      8'h60: d.kind = K_RTS;
      8'h40: d.kind = K_RTI;
      8'h00: d.kind = K_BRK;
      8'h48, 8'h08: d.kind = K_PUSH;
      8'h68, 8'h28: d.kind = K_PULL;
      default: d.kind = K_UNKNOWN;
    endcase
    return d;
  endfunction

endpackage

@@ sv/cpu6502_subset_bus_core_top.sv @@
`timescale 1ns / 1ps
// 6502 instruction subset core, one bus access per beat, binary ADC only.
// Slave channel (s_axis_*): each beat carries the byte read for the previous
// request; the first beat after reset carries nothing and starts the opcode
// fetch at start_address. Master channel (m_axis_*): one beat per input beat
// with the next bus address, direction, write data and opcode fetch and
// unknown opcode flags.
// A result is registered at the edge that accepts its input beat. Throughput
// is one beat per cycle while the output is not stalled; the registers,
// decode, ADC and address adders sit between the input handshake and the output register.
// The output register is the only buffer: a new beat is taken when it is
// empty or being drained in the same cycle, so a stalled receiver holds the
// result and back-pressures the input.
// Reset clears registers to A=X=Y=0, P=0x24, S=0xFD, phase zero, and
// start_address to zero. The user must write start_address through
// cfg_wr/cfg_data only while the core is idle; the core does not enforce
// this. start_address is sampled on the first beat after reset. Unknown
// opcodes are executed as one byte no-ops, flagged on the fetch that follows them.
module cpu6502_subset_bus_core_top
  import c6502_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] read_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] bus_address, [16] bus_write,
                                      // [24:17] write_data, [25] opcode_fetch,
                                      // [26] unknown_opcode, [31:27] zero
);

  logic [15:0] start_address;
  logic [7:0]  acc, xr, yr, pr, sp;
  logic [15:0] pc, alat;
  logic [7:0]  cur_op;
  logic [2:0]  phase;

  logic [7:0]  acc_next, xr_next, yr_next, pr_next, sp_next, cur_op_next;
  logic [15:0] pc_next, alat_next;
  logic [2:0]  phase_next;

  logic [15:0] addr;
  logic        wr, fetch, unk;
  logic [7:0]  wdata;
  logic        take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  // Set N and Z from a result byte.
  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    return {v[7], p[6:2], (v == 8'h00), p[0]};
  endfunction

  // One bus cycle of execution.
  always_comb begin
    decoded_t d;
    logic [7:0] rd;
    logic [8:0] sum;
    logic [7:0] idx;
    logic [15:0] ea;
    logic access;
    logic [15:0] ret;
    rd = s_axis_tdata;
    acc_next = acc; xr_next = xr; yr_next = yr; pr_next = pr; sp_next = sp;
    pc_next = pc; alat_next = alat; cur_op_next = cur_op; phase_next = phase;
    addr = 16'h0000; wr = 1'b0; wdata = 8'h00; fetch = 1'b0; unk = 1'b0;
    access = 1'b0; ea = 16'h0000; sum = 9'h000; idx = 8'h00;
    ret = pc - 16'd1;
    d = decode(cur_op);
    if (phase == 3'd0) begin
      pc_next = start_address;
      fetch = 1'b1;
    end else if (phase == 3'd1) begin
      cur_op_next = rd;
      d = decode(rd);
      case (d.kind)
        K_IMPLIED: begin
          fetch = 1'b1;
          case (rd)
            8'hAA: begin xr_next = acc; pr_next = nz(pr, acc); end
            8'hA8: begin yr_next = acc; pr_next = nz(pr, acc); end
            8'h8A: begin acc_next = xr; pr_next = nz(pr, xr); end
            8'h98: begin acc_next = yr; pr_next = nz(pr, yr); end
            8'hBA: begin xr_next = sp; pr_next = nz(pr, sp); end
            8'h9A: sp_next = xr;
            8'hE8: begin xr_next = xr + 8'd1; pr_next = nz(pr, xr + 8'd1); end
            8'hC8: begin yr_next = yr + 8'd1; pr_next = nz(pr, yr + 8'd1); end
            8'hCA: begin xr_next = xr - 8'd1; pr_next = nz(pr, xr - 8'd1); end
            8'h88: begin yr_next = yr - 8'd1; pr_next = nz(pr, yr - 8'd1); end
            8'h18: pr_next = pr & 8'hFE;
            8'h38: pr_next = pr | 8'h01;
            8'hD8: pr_next = pr & 8'hF7;
            8'h58: pr_next = pr & 8'hFB;
            8'h78: pr_next = pr | 8'h04;
            default: pr_next = pr;
          endcase
        end
        K_MEM, K_JMPA, K_JMPI, K_JSR: begin
          addr = pc; pc_next = pc + 16'd1; phase_next = 3'd2;
        end
        K_RTS, K_RTI, K_PULL: begin
          sp_next = sp + 8'd1; addr = {STACK_PAGE, sp + 8'd1}; phase_next = 3'd2;
        end
        K_PUSH: begin
          addr = {STACK_PAGE, sp}; wr = 1'b1;
          wdata = (rd == OPC_PHA) ? acc : (pr | BRK_BITS);
          sp_next = sp - 8'd1; phase_next = 3'd2;
        end
        K_BRK: begin
          pc_next = pc + 16'd1;
          addr = {STACK_PAGE, sp}; wr = 1'b1; wdata = pc_next[15:8];
          sp_next = sp - 8'd1; phase_next = 3'd2;
        end
        default: begin unk = 1'b1; fetch = 1'b1; end
      endcase
    end else if (d.kind == K_MEM) begin
      case (phase)
        3'd2: begin
          case (d.mode)
            AM_IMM: fetch = 1'b1;
            AM_ZP: begin ea = {8'h00, rd}; access = 1'b1; end
            AM_ZPX: begin ea = {8'h00, rd + xr}; access = 1'b1; end
            AM_ZPY: begin ea = {8'h00, rd + yr}; access = 1'b1; end
            AM_INDX: begin
              alat_next = {8'h00, rd + xr}; addr = alat_next; phase_next = 3'd4;
            end
            AM_INDY: begin
              alat_next = {8'h00, rd}; addr = alat_next; phase_next = 3'd4;
            end
            default: begin
              alat_next = {8'h00, rd}; addr = pc; pc_next = pc + 16'd1; phase_next = 3'd3;
            end
          endcase
        end
        3'd3: begin
          idx = (d.mode == AM_ABSX) ? xr : ((d.mode == AM_ABSY) ? yr : 8'h00);
          ea = {rd, alat[7:0]} + {8'h00, idx};
          access = 1'b1;
        end
        3'd4: begin
          alat_next = {rd, alat[7:0]};
          addr = {8'h00, alat[7:0] + 8'd1};
          phase_next = 3'd5;
        end
        3'd5: begin
          idx = (d.mode == AM_INDY) ? yr : 8'h00;
          ea = {rd, alat[15:8]} + {8'h00, idx};
          access = 1'b1;
        end
        default: fetch = 1'b1;
      endcase
      // Operand applies on immediate or on the data read that follows.
      if ((phase == 3'd2 && d.mode == AM_IMM) || phase == 3'd6) begin
        case (d.oper)
          OP_LDA: begin acc_next = rd; pr_next = nz(pr, rd); end
          OP_LDX: begin xr_next = rd; pr_next = nz(pr, rd); end
          OP_LDY: begin yr_next = rd; pr_next = nz(pr, rd); end
          OP_ADC: begin
            sum = {1'b0, acc} + {1'b0, rd} + {8'h00, pr[0]};
            acc_next = sum[7:0];
            pr_next = nz({pr[7], ~(acc[7] ^ rd[7]) & (acc[7] ^ sum[7]), pr[5:1], sum[8]},
                         sum[7:0]);
          end
          default: pr_next = pr;
        endcase
      end
      if (access) begin
        addr = ea;
        if (d.oper == OP_STA) begin
          wr = 1'b1; wdata = acc; phase_next = 3'd7;
        end else begin
          phase_next = 3'd6;
        end
      end
    end else if (d.kind == K_JMPA || d.kind == K_JMPI || d.kind == K_JSR) begin
      if (phase == 3'd2) begin
        alat_next = {8'h00, rd}; addr = pc; pc_next = pc + 16'd1; phase_next = 3'd3;
      end else if (phase == 3'd3) begin
        alat_next = {rd, alat[7:0]};
        if (d.kind == K_JMPA) begin
          pc_next = alat_next; fetch = 1'b1;
        end else if (d.kind == K_JMPI) begin
          addr = alat_next; phase_next = 3'd4;
        end else begin
          addr = {STACK_PAGE, sp}; wr = 1'b1; wdata = ret[15:8];
          sp_next = sp - 8'd1; phase_next = 3'd4;
        end
      end else if (phase == 3'd4 && d.kind == K_JMPI) begin
        pc_next = {8'h00, rd};
        addr = {alat[15:8], alat[7:0] + 8'd1};
        phase_next = 3'd5;
      end else if (phase == 3'd4) begin
        addr = {STACK_PAGE, sp}; wr = 1'b1; wdata = ret[7:0];
        sp_next = sp - 8'd1; pc_next = alat; phase_next = 3'd5;
      end else if (phase == 3'd5 && d.kind == K_JMPI) begin
        pc_next = {rd, pc[7:0]}; fetch = 1'b1;
      end else begin
        fetch = 1'b1;
      end
    end else if (d.kind == K_RTS || d.kind == K_RTI) begin
      if (phase == 3'd2 && d.kind == K_RTI) begin
        pr_next = (rd & 8'hEF) | 8'h20;
        sp_next = sp + 8'd1; addr = {STACK_PAGE, sp + 8'd1}; phase_next = 3'd3;
      end else if ((phase == 3'd2 && d.kind == K_RTS) || (phase == 3'd3 && d.kind == K_RTI)) begin
        alat_next = {8'h00, rd};
        sp_next = sp + 8'd1; addr = {STACK_PAGE, sp + 8'd1}; phase_next = phase + 3'd1;
      end else if (phase == 3'd3 && d.kind == K_RTS) begin
        pc_next = {rd, alat[7:0]} + 16'd1; fetch = 1'b1;
      end else if (phase == 3'd4 && d.kind == K_RTI) begin
        pc_next = {rd, alat[7:0]}; fetch = 1'b1;
      end else begin
        fetch = 1'b1;
      end
    end else if (d.kind == K_BRK) begin
      case (phase)
        3'd2: begin
          addr = {STACK_PAGE, sp}; wr = 1'b1; wdata = pc[7:0];
          sp_next = sp - 8'd1; phase_next = 3'd3;
        end
        3'd3: begin
          addr = {STACK_PAGE, sp}; wr = 1'b1; wdata = pr | BRK_BITS;
          sp_next = sp - 8'd1; pr_next = pr | 8'h04; phase_next = 3'd4;
        end
        3'd4: begin addr = IRQ_VECTOR; phase_next = 3'd5; end
        3'd5: begin
          alat_next = {8'h00, rd}; addr = IRQ_VECTOR + 16'd1; phase_next = 3'd6;
        end
        3'd6: begin pc_next = {rd, alat[7:0]}; fetch = 1'b1; end
        default: fetch = 1'b1;
      endcase
    end else if (d.kind == K_PULL && phase == 3'd2) begin
      if (cur_op == OPC_PLA) begin
        acc_next = rd; pr_next = nz(pr, rd);
      end else begin
        pr_next = (rd & 8'hEF) | 8'h20;
      end
      fetch = 1'b1;
    end else begin
      fetch = 1'b1;
    end
    if (fetch) begin
      addr = pc_next; wr = 1'b0; wdata = 8'h00;
      pc_next = pc_next + 16'd1;
      phase_next = 3'd1;
    end
  end

  // Architectural state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= 16'h0000;
      acc <= 8'h00; xr <= 8'h00; yr <= 8'h00;
      pr <= STATUS_RESET; sp <= SP_RESET;
      pc <= 16'h0000; alat <= 16'h0000; cur_op <= 8'h00; phase <= 3'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_address <= cfg_data;
      end
      if (take) begin
        acc <= acc_next; xr <= xr_next; yr <= yr_next; pr <= pr_next; sp <= sp_next;
        pc <= pc_next; alat <= alat_next; cur_op <= cur_op_next; phase <= phase_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {5'b00000, unk, fetch, wdata, wr, addr};
    end
  end

  // A write beat never flags an opcode fetch.
  a_write_not_fetch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[16] && m_axis_tdata[25]))
    else $error("write flagged as opcode fetch");

  // Unknown opcode is only reported on a fetch.
  a_unk_fetch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[25])
    else $error("unknown opcode without fetch");

  // After a fetch is accepted the core is decoding.
  a_fetch_phase: assert property (@(posedge clk) disable iff (rst)
    take && fetch |=> phase == 3'd1)
    else $error("fetch did not enter decode");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

endmodule
